[sv/irfe_pkg.sv]
// Shared constants, types and orientation helpers of the image rotate/flip engine.
`default_nettype none
package irfe_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  // input item kinds
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_OP   = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // operation codes
  localparam logic [1:0] OP_ROT_CW   = 2'd0;
  localparam logic [1:0] OP_ROT_CCW  = 2'd1;
  localparam logic [1:0] OP_MIR_COLS = 2'd2;
  localparam logic [1:0] OP_MIR_ROWS = 2'd3;

  // orientation bit positions: transpose, row flip, column flip
  localparam int ORI_T  = 2;
  localparam int ORI_FR = 1;
  localparam int ORI_FC = 0;

  localparam int QUEUE_DEPTH = 4;
  localparam int FLAGS_W = 3;

  typedef struct packed {
    logic is_read;
    logic row_end;
    logic frame_end;
  } cmd_flags_t;

  function automatic logic [2:0] mirror_cols(input logic [2:0] ori);
    logic [2:0] o;
    begin
      o = ori;
      if (o[ORI_T]) o[ORI_FR] = ~o[ORI_FR];
      else          o[ORI_FC] = ~o[ORI_FC];
      return o;
    end
  endfunction

  function automatic logic [2:0] mirror_rows(input logic [2:0] ori);
    logic [2:0] o;
    begin
      o = ori;
      if (o[ORI_T]) o[ORI_FC] = ~o[ORI_FC];
      else          o[ORI_FR] = ~o[ORI_FR];
      return o;
    end
  endfunction

  // fold one operation into the orientation
  function automatic logic [2:0] apply_op(input logic [2:0] ori, input logic [1:0] op);
    logic [2:0] o;
    begin
      o = ori;
      case (op)
        OP_ROT_CW: begin
          o[ORI_T] = ~o[ORI_T];
          o = mirror_cols(o);
        end
        OP_ROT_CCW: begin
          o[ORI_T] = ~o[ORI_T];
          o = mirror_rows(o);
        end
        OP_MIR_COLS: o = mirror_cols(o);
        OP_MIR_ROWS: o = mirror_rows(o);
        default: o = ori;
      endcase
      return o;
    end
  endfunction

endpackage
`default_nettype wire

[sv/irfe_if.sv]
// Valid/ready channel interfaces for input items and result pixels.
`default_nettype none
interface irfe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [irfe_pkg::PIX_W-1:0] pixel_in;
  logic [1:0] op_code;

  modport source (output valid, output func, output pixel_in, output op_code, input ready);
  modport sink (input valid, input func, input pixel_in, input op_code, output ready);
endinterface

interface irfe_out_if;
  logic valid;
  logic ready;
  logic [irfe_pkg::PIX_W-1:0] pixel_out;
  logic row_end;
  logic frame_end;

  modport source (output valid, output pixel_out, output row_end, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input row_end, input frame_end, output ready);
endinterface
`default_nettype wire

[sv/image_rotate_flip_engine.sv]
// Image rotate/flip engine top level.
//
// Items arrive on in_i (valid/ready): func selects a pixel load, an operation
// (rotate clockwise, rotate counterclockwise, mirror columns, mirror rows) or
// a read of the next output pixel. Only reads give a result, sent on out_o with
// end-of-row and end-of-frame marks, in raster order of the transformed image.
// Operations only fold into a 3-bit orientation; pixels never move in the store.
// rows and cols are set through the cfg_we_i/cfg_idx_i/cfg_data_i write port;
// the user must write them only while the engine is idle, as the block does not
// enforce it; a write to either restarts loading, resets the orientation and
// returns the read position to the first pixel. Throughput: one item per cycle
// while the queue is not full; every load and read uses the single frame store
// port. A read passes the queue entry, the frame store read and the result register.
// A four-entry queue parts item intake from frame store access, so intake keeps
// going while out_o stalls until the queue and the read pipeline fill.
// Reset clears control state: dimensions to 1x1, identity orientation, empty
// queue; the frame store holds no defined data until loaded.
`default_nettype none
module image_rotate_flip_engine #(
  parameter int MAX_DIM = 128
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [irfe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [irfe_pkg::CFG_W-1:0]     cfg_data_i,
  irfe_in_if.sink                             in_i,
  irfe_out_if.source                          out_o
);

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int QW = AW + irfe_pkg::PIX_W + irfe_pkg::FLAGS_W;

  logic          push, full, pop, empty;
  logic [QW-1:0] push_data, head;

  irfe_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  irfe_queue #(.W(QW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  irfe_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

[sv/irfe_queue.sv]
// Short command queue between the front and the back of the engine.
`default_nettype none
module irfe_queue #(
  parameter int W = 28
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] push_data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              empty_o,
  output logic [W-1:0]      head_o
);

  localparam int D  = irfe_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);
  localparam int CW = $clog2(D + 1);

  logic [W-1:0]  entry_q [D];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(D));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? PW'(wr_ptr_q + PW'(1)) : wr_ptr_q;
    rd_ptr_d = do_pop ? PW'(rd_ptr_q + PW'(1)) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + CW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(D))
    else $error("queue fill count above depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CW'(D)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

[sv/irfe_front.sv]
// Front end: takes items and configuration, tracks orientation and read position.
`default_nettype none
module irfe_front #(
  parameter int MAX_DIM = 128
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [irfe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [irfe_pkg::CFG_W-1:0]      cfg_data_i,
  irfe_in_if.sink                              in_i,
  input  wire logic                            full_i,
  output logic                                 push_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)+irfe_pkg::PIX_W+irfe_pkg::FLAGS_W-1:0] push_data_o
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int LW = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int CW = (DW > irfe_pkg::CFG_W) ? DW : irfe_pkg::CFG_W;
  localparam int PW = IW + DW;

  function automatic logic [DW-1:0] eff_dim(input logic [irfe_pkg::CFG_W-1:0] v);
    logic [CW-1:0] ext;
    begin
      ext = CW'(v);
      if (ext == '0) return DW'(1);
      if (ext > CW'(MAX_DIM)) return DW'(MAX_DIM);
      return DW'(ext);
    end
  endfunction

  logic [DW-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [LW-1:0] load_cnt_q, load_cnt_d;
  logic [2:0]    ori_q, ori_d;
  logic [IW-1:0] rd_row_q, rd_row_d, rd_col_q, rd_col_d;

  logic              accept, is_load, is_read, is_op, load_ok;
  logic [2*DW-1:0]   area;
  logic              t_bit;
  logic [DW-1:0]     h, w;
  logic [IW-1:0]     a_idx, b_idx;
  logic [PW-1:0]     lin_addr;
  logic              row_end, frame_end;
  logic [AW-1:0]     addr;
  irfe_pkg::cmd_flags_t flags;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_load    = (in_i.func == irfe_pkg::FUNC_LOAD);
  assign is_op      = (in_i.func == irfe_pkg::FUNC_OP);
  assign is_read    = (in_i.func == irfe_pkg::FUNC_READ);

  assign area    = (2*DW)'(rows_q) * (2*DW)'(cols_q);
  assign load_ok = ((2*DW)'(load_cnt_q) < area);

  // map the output position back to the source pixel
  always_comb begin
    t_bit = ori_q[irfe_pkg::ORI_T];
    h     = t_bit ? cols_q : rows_q;
    w     = t_bit ? rows_q : cols_q;
    a_idx = t_bit ? rd_col_q : rd_row_q;
    b_idx = t_bit ? rd_row_q : rd_col_q;
    if (ori_q[irfe_pkg::ORI_FR]) a_idx = IW'(rows_q - DW'(1) - DW'(a_idx));
    if (ori_q[irfe_pkg::ORI_FC]) b_idx = IW'(cols_q - DW'(1) - DW'(b_idx));
    lin_addr  = PW'(PW'(a_idx) * PW'(cols_q) + PW'(b_idx));
    row_end   = (DW'(rd_col_q) == w - DW'(1));
    frame_end = row_end && (DW'(rd_row_q) == h - DW'(1));
  end

  always_comb begin
    flags.is_read   = is_read;
    flags.row_end   = row_end;
    flags.frame_end = frame_end;
    addr            = is_read ? lin_addr[AW-1:0] : load_cnt_q[AW-1:0];
    push_o          = accept && (is_read || (is_load && load_ok));
    push_data_o     = {flags, in_i.pixel_in, addr};
  end

  always_comb begin
    rows_d     = rows_q;
    cols_d     = cols_q;
    load_cnt_d = load_cnt_q;
    ori_d      = ori_q;
    rd_row_d   = rd_row_q;
    rd_col_d   = rd_col_q;
    if (cfg_we_i && (cfg_idx_i == irfe_pkg::REG_ROWS || cfg_idx_i == irfe_pkg::REG_COLS)) begin
      if (cfg_idx_i == irfe_pkg::REG_ROWS) rows_d = eff_dim(cfg_data_i);
      else                                 cols_d = eff_dim(cfg_data_i);
      load_cnt_d = '0;
      ori_d      = '0;
      rd_row_d   = '0;
      rd_col_d   = '0;
    end else if (accept) begin
      if (is_load && load_ok) begin
        load_cnt_d = load_cnt_q + LW'(1);
      end else if (is_op) begin
        ori_d    = irfe_pkg::apply_op(ori_q, in_i.op_code);
        rd_row_d = '0;
        rd_col_d = '0;
      end else if (is_read) begin
        // advance the raster position, wrap at the end of the frame
        if (row_end) begin
          rd_col_d = '0;
          rd_row_d = frame_end ? '0 : IW'(rd_row_q + IW'(1));
        end else begin
          rd_col_d = IW'(rd_col_q + IW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= DW'(1);
      cols_q     <= DW'(1);
      load_cnt_q <= '0;
      ori_q      <= '0;
      rd_row_q   <= '0;
      rd_col_q   <= '0;
    end else begin
      rows_q     <= rows_d;
      cols_q     <= cols_d;
      load_cnt_q <= load_cnt_d;
      ori_q      <= ori_d;
      rd_row_q   <= rd_row_d;
      rd_col_q   <= rd_col_d;
    end
  end

  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (2*DW)'(load_cnt_q) <= area)
    else $error("load count beyond frame size");

  a_pos_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DW'(rd_row_q) < h) && (DW'(rd_col_q) < w))
    else $error("read position outside current dimensions");

endmodule
`default_nettype wire

[sv/irfe_back.sv]
// Back end: frame store writes and reads, read pipeline and result register.
`default_nettype none
module irfe_back #(
  parameter int MAX_DIM = 128
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic empty_i,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM)+irfe_pkg::PIX_W+irfe_pkg::FLAGS_W-1:0] head_i,
  output logic      pop_o,
  irfe_out_if.source out_o
);

  localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int PXW   = irfe_pkg::PIX_W;

  logic [PXW-1:0] store_q [DEPTH];
  logic [PXW-1:0] rd_data_q;

  irfe_pkg::cmd_flags_t head_flags;
  logic [AW-1:0]        head_addr;
  logic [PXW-1:0]       head_pix;

  logic s1_v_q, s1_v_d, s1_re_q, s1_fe_q;
  logic out_v_q, out_v_d, out_re_q, out_fe_q;
  logic [PXW-1:0] out_pix_q;
  logic s1_adv, s1_free, wr_en, rd_en;

  assign head_addr  = head_i[AW-1:0];
  assign head_pix   = head_i[AW+PXW-1:AW];
  assign head_flags = irfe_pkg::cmd_flags_t'(head_i[AW+PXW+irfe_pkg::FLAGS_W-1:AW+PXW]);

  // stage one moves on when the result register is free or drains
  assign s1_adv  = !out_v_q || out_o.ready;
  assign s1_free = !s1_v_q || s1_adv;
  assign wr_en   = !empty_i && !head_flags.is_read;
  assign rd_en   = !empty_i && head_flags.is_read && s1_free;
  assign pop_o   = wr_en || rd_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) store_q[head_addr] <= head_pix;
    if (rd_en) rd_data_q <= store_q[head_addr];
  end

  always_comb begin
    s1_v_d  = rd_en ? 1'b1 : (s1_adv ? 1'b0 : s1_v_q);
    out_v_d = (s1_v_q && s1_adv) ? 1'b1 : (out_o.ready ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_re_q <= head_flags.row_end;
      s1_fe_q <= head_flags.frame_end;
    end
    if (s1_v_q && s1_adv) begin
      out_pix_q <= rd_data_q;
      out_re_q  <= s1_re_q;
      out_fe_q  <= s1_fe_q;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.pixel_out = out_pix_q;
  assign out_o.row_end   = out_re_q;
  assign out_o.frame_end = out_fe_q;

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_v_q && !out_o.ready) |=> s1_v_q)
    else $error("read in flight dropped while result stalled");

  a_no_read_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_v_q && !out_o.ready) |-> !rd_en)
    else $error("frame store read issued with no room downstream");

endmodule
`default_nettype wire
